// File: src/asqm_pkg.sv
`timescale 1ns / 1ps
package asqm_pkg;
  localparam int unsigned AVG_FRAC_BITS_DEF = 24;
  localparam logic [15:0] STUCK_LIMIT_RST = 16'd600;
  localparam logic [23:0] AVG_GAIN_RST = 24'd168;
  localparam logic [23:0] RANGE_ENTER_RST = 24'd26214;
  localparam logic [23:0] RANGE_EXIT_RST = 24'd19661;
  localparam logic [15:0] RATE_LOW_RST = 16'd88;
  localparam logic [15:0] RATE_HIGH_RST = 16'd112;
  localparam logic [5:0] LAST_SECOND = 6'd59;
  localparam int unsigned SQRT_STEPS = 25;

  localparam logic [2:0] REG_STUCK_LIMIT = 3'd0;
  localparam logic [2:0] REG_AVG_GAIN = 3'd1;
  localparam logic [2:0] REG_RANGE_ENTER = 3'd2;
  localparam logic [2:0] REG_RANGE_EXIT = 3'd3;
  localparam logic [2:0] REG_RATE_LOW = 3'd4;
  localparam logic [2:0] REG_RATE_HIGH = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_HI, ST_SQRT, ST_SUB, ST_MUL, ST_ACC, ST_FLAGS, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic sqrt_step;
    logic sub;
    logic mul;
    logic mul_hi;
    logic acc;
    logic flags;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } status_t;
endpackage

// File: src/asqm_ctrl.sv
`timescale 1ns / 1ps
module asqm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  asqm_pkg::status_t   status,
  output asqm_pkg::cmd_t      cmd
);
  asqm_pkg::state_t state_r, state_nxt;
  logic             oval_r, oval_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= asqm_pkg::ST_IDLE;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      oval_r  <= oval_nxt;
    end
  end

  // result register frees as soon as it is taken, next sample may load meanwhile
  always_comb begin
    state_nxt = state_r;
    oval_nxt  = oval_r && !out_tready;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      asqm_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = asqm_pkg::ST_SQRT;
        end
      end
      asqm_pkg::ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (status.sqrt_done) state_nxt = asqm_pkg::ST_SUB;
      end
      asqm_pkg::ST_SUB: begin
        cmd.sub   = 1'b1;
        state_nxt = asqm_pkg::ST_MUL;
      end
      asqm_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = asqm_pkg::ST_MUL_HI;
      end
      asqm_pkg::ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = asqm_pkg::ST_ACC;
      end
      asqm_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = asqm_pkg::ST_OUT;
      end
      asqm_pkg::ST_OUT: begin
        if (!oval_nxt) begin
          cmd.flags = 1'b1;
          oval_nxt  = 1'b1;
          state_nxt = asqm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = asqm_pkg::ST_IDLE;
    endcase
  end

  assign out_tvalid = oval_r;
endmodule

// File: src/asqm_datapath.sv
`timescale 1ns / 1ps
module asqm_datapath #(
  parameter int unsigned AVERAGE_FRACTION_BITS = asqm_pkg::AVG_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  asqm_pkg::cmd_t     cmd,
  output asqm_pkg::status_t  status,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic [5:0]         second_of_minute,
  input  logic               recording_restart,
  input  logic [15:0]        stuck_limit,
  input  logic [23:0]        average_gain,
  input  logic [23:0]        range_enter,
  input  logic [23:0]        range_exit,
  input  logic [15:0]        rate_low,
  input  logic [15:0]        rate_high,
  output logic [110:0]       result
);
  localparam int unsigned AW = 25 + AVERAGE_FRACTION_BITS;
  localparam int unsigned DW = AW + 1;
  localparam int unsigned PW = DW + 24;
  localparam int unsigned CW = $clog2(asqm_pkg::SQRT_STEPS + 1);

  // stuck / rate state
  logic signed [15:0] hx_r, hy_r, hz_r;
  logic [15:0] run_r;
  logic [5:0]  psec_r;
  logic        psec_v_r, first_r;
  logic [15:0] scnt_r;
  // per-sample snapshot
  logic signed [15:0] x_r, y_r, z_r;
  logic [5:0]  sec_r;
  logic        rst_req_r;
  logic        salarm_r, srel_r;
  // square root
  logic [49:0] rem_r;
  logic [24:0] root_r;
  logic [CW-1:0] step_r;
  logic [49:0] sq_r;
  // average
  logic signed [AW-1:0] acc_r;
  logic signed [DW-1:0] diff_r;
  logic [48:0] prod_lo_r;
  logic signed [PW-1:0] prod_r;
  logic [23:0] peak_r, max_r;
  logic        oor_r;
  logic [110:0] res_r;

  logic [33:0] sq_sum;
  assign sq_sum = 34'(x_r * x_r) + 34'(y_r * y_r) + 34'(z_r * z_r);

  // one result bit per step, restoring method on a 50 bit radicand
  logic [49:0] rem_sh;
  logic [26:0] trial;
  logic [49:0] sq_sh;
  assign rem_sh = {rem_r[47:0], sq_r[49:48]};
  assign sq_sh  = {sq_r[47:0], 2'b00};
  assign trial  = {root_r, 2'b01};
  assign status.sqrt_done = (step_r == CW'(asqm_pkg::SQRT_STEPS));

  logic signed [DW-1:0] mterm;
  assign mterm = DW'($signed({1'b0, root_r}) - 26'sd65536) <<< AVERAGE_FRACTION_BITS;

  // upper half of the gain product, lower half comes from the previous cycle
  logic signed [PW-1:0] prod_hi;
  assign prod_hi = PW'($signed(diff_r[DW-1:25]) * $signed({1'b0, average_gain}));

  logic signed [PW:0] acc_sum;
  logic signed [AW-1:0] acc_sat;
  logic signed [PW-AVERAGE_FRACTION_BITS-1:0] avg_w;
  logic [PW-AVERAGE_FRACTION_BITS-1:0] avg_abs;
  logic [23:0] aabs;
  localparam logic signed [AW-1:0] AMAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] AMIN = {1'b1, {(AW-1){1'b0}}};
  always_comb begin
    acc_sum = (PW+1)'(acc_r) + (PW+1)'(prod_r >>> 24);
    if (acc_sum > (PW+1)'(AMAX)) acc_sat = AMAX;
    else if (acc_sum < (PW+1)'(AMIN)) acc_sat = AMIN;
    else acc_sat = AW'(acc_sum);
  end

  logic signed [24:0] avg_r;
  always_comb begin
    avg_w   = (PW-AVERAGE_FRACTION_BITS)'(acc_r >>> AVERAGE_FRACTION_BITS);
    avg_abs = avg_w[PW-AVERAGE_FRACTION_BITS-1] ? -avg_w : avg_w;
    aabs    = (avg_abs > 24'hFFFFFF) ? 24'hFFFFFF : avg_abs[23:0];
  end

  // rate check on the snapshot
  logic [5:0] ps;
  logic       pv_sec_chg, seq;
  logic [15:0] cnt_base;
  always_comb begin
    ps = (rst_req_r || !psec_v_r) ? sec_r : psec_r;
    pv_sec_chg = (sec_r != ps);
    seq = ({1'b0, sec_r} == {1'b0, ps} + 7'd1) ||
          (sec_r == 6'd0 && ps == asqm_pkg::LAST_SECOND);
    cnt_base = pv_sec_chg ? 16'd0 : scnt_r;
  end
  logic in_band, first_now;
  assign first_now = rst_req_r | first_r;
  assign in_band = (scnt_r >= rate_low) && (scnt_r <= rate_high);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hx_r <= '0; hy_r <= '0; hz_r <= '0; run_r <= '0;
      psec_r <= '0; psec_v_r <= 1'b0; first_r <= 1'b1; scnt_r <= '0;
      acc_r <= '0; peak_r <= '0; max_r <= '0; oor_r <= 1'b0;
      step_r <= '0;
    end else begin
      if (cmd.load) begin
        step_r <= '0;
        salarm_r <= 1'b0;
        srel_r <= 1'b0;
        if (accel_x == hx_r && accel_y == hy_r && accel_z == hz_r) begin
          if (run_r != 16'hFFFF) begin
            run_r <= run_r + 16'd1;
            salarm_r <= (run_r + 16'd1) == stuck_limit;
          end
        end else begin
          srel_r <= run_r >= stuck_limit;
          hx_r <= accel_x; hy_r <= accel_y; hz_r <= accel_z;
          run_r <= '0;
        end
      end
      if (cmd.sqrt_step) step_r <= step_r + CW'(1);
      if (cmd.acc) acc_r <= acc_sat;
      if (cmd.flags) begin
        logic ra, rr, re, br;
        logic [23:0] pk;
        ra = 1'b0; rr = 1'b0; re = 1'b0; br = 1'b0;
        pk = (aabs > peak_r) ? aabs : peak_r;
        if (aabs > max_r) max_r <= aabs;
        if (aabs > range_enter) begin
          if (!oor_r) begin
            ra = 1'b1; oor_r <= 1'b1; pk = aabs;
          end
        end else if (aabs < range_exit && oor_r) begin
          oor_r <= 1'b0; rr = 1'b1;
        end
        peak_r <= pk;
        psec_v_r <= 1'b1;
        psec_r <= sec_r;
        if (pv_sec_chg) begin
          first_r <= 1'b0;
          if (!first_now && !in_band) begin
            re = seq; br = !seq;
          end
        end else begin
          first_r <= first_now;
        end
        scnt_r <= (cnt_base == 16'hFFFF) ? cnt_base : cnt_base + 16'd1;
        res_r <= {(pv_sec_chg ? scnt_r : 16'd0), br, re,
                  ((aabs > max_r) ? aabs : max_r), pk, avg_r, rr, ra,
                  run_r, srel_r, salarm_r};
      end
    end
  end

  // payload only
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= accel_x; y_r <= accel_y; z_r <= accel_z;
      sec_r <= second_of_minute;
      rst_req_r <= recording_restart;
      rem_r <= '0;
      root_r <= '0;
    end
    if (step_r == '0 && cmd.sqrt_step) begin
      sq_r <= {sq_sum, 16'd0};
      rem_r <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      sq_r <= sq_sh;
      if (rem_sh >= 50'(trial)) begin
        rem_r <= rem_sh - 50'(trial);
        root_r <= {root_r[23:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        root_r <= {root_r[23:0], 1'b0};
      end
    end
    if (cmd.sub) diff_r <= mterm - DW'(acc_r);
    if (cmd.mul) prod_lo_r <= diff_r[24:0] * average_gain;
    if (cmd.mul_hi) prod_r <= (prod_hi <<< 25) + PW'(prod_lo_r);
    if (cmd.acc) avg_r <= 25'(acc_sat >>> AVERAGE_FRACTION_BITS);
  end

  assign result = res_r;
endmodule

// File: src/asqm_regs.sv
`timescale 1ns / 1ps
module asqm_regs (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic [15:0] stuck_limit,
  output logic [23:0] average_gain,
  output logic [23:0] range_enter,
  output logic [23:0] range_exit,
  output logic [15:0] rate_low,
  output logic [15:0] rate_high
);
  logic [15:0] sl_r, rl_r, rh_r;
  logic [23:0] ag_r, re_r, rx_r;
  logic        wr;
  logic [2:0]  idx;
  assign wr  = psel & penable & pwrite;
  assign idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sl_r <= asqm_pkg::STUCK_LIMIT_RST;
      ag_r <= asqm_pkg::AVG_GAIN_RST;
      re_r <= asqm_pkg::RANGE_ENTER_RST;
      rx_r <= asqm_pkg::RANGE_EXIT_RST;
      rl_r <= asqm_pkg::RATE_LOW_RST;
      rh_r <= asqm_pkg::RATE_HIGH_RST;
    end else if (wr) begin
      unique case (idx)
        asqm_pkg::REG_STUCK_LIMIT: sl_r <= pwdata[15:0];
        asqm_pkg::REG_AVG_GAIN:    ag_r <= pwdata[23:0];
        asqm_pkg::REG_RANGE_ENTER: re_r <= pwdata[23:0];
        asqm_pkg::REG_RANGE_EXIT:  rx_r <= pwdata[23:0];
        asqm_pkg::REG_RATE_LOW:    rl_r <= pwdata[15:0];
        asqm_pkg::REG_RATE_HIGH:   rh_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      asqm_pkg::REG_STUCK_LIMIT: prdata = {16'd0, sl_r};
      asqm_pkg::REG_AVG_GAIN:    prdata = {8'd0, ag_r};
      asqm_pkg::REG_RANGE_ENTER: prdata = {8'd0, re_r};
      asqm_pkg::REG_RANGE_EXIT:  prdata = {8'd0, rx_r};
      asqm_pkg::REG_RATE_LOW:    prdata = {16'd0, rl_r};
      asqm_pkg::REG_RATE_HIGH:   prdata = {16'd0, rh_r};
      default:                   prdata = '0;
    endcase
  end

  assign stuck_limit = sl_r;
  assign average_gain = ag_r;
  assign range_enter = re_r;
  assign range_exit = rx_r;
  assign rate_low = rl_r;
  assign rate_high = rh_r;
endmodule

// File: src/accel_stream_quality_monitor.sv
`timescale 1ns / 1ps
// a sample passes the bit-serial square root, then sub, two multiply halves (low, then high),
// acc and out; out holds while the previous result has not yet been taken
// a new sample is taken only after the current one has left out and the controller is back in idle
// the input beat of the next sample is taken while the last result waits
// reset: synchronous active-low rst_n; registers to defaults, all tracking state cleared
module accel_stream_quality_monitor #(
  parameter int unsigned AVERAGE_FRACTION_BITS = asqm_pkg::AVG_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // accel_x, accel_y, accel_z, second_of_minute, pad
  input  logic         in_tuser,   // recording_restart
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata,  // stuck_alarm, stuck_released, repeat_run, range_alarm,
                                   // range_restored, average_deviation, peak_deviation,
                                   // max_deviation, rate_error, second_break,
                                   // samples_last_second, pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);
  asqm_pkg::cmd_t    cmd;
  asqm_pkg::status_t status;
  logic [15:0] stuck_limit, rate_low, rate_high;
  logic [23:0] average_gain, range_enter, range_exit;
  logic [110:0] result;

  assign cfg_pready = 1'b1;

  asqm_regs u_regs (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .stuck_limit, .average_gain, .range_enter, .range_exit, .rate_low, .rate_high
  );

  // controller sequences one sample through the datapath
  asqm_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .status, .cmd
  );

  asqm_datapath #(.AVERAGE_FRACTION_BITS(AVERAGE_FRACTION_BITS)) u_dp (
    .clk, .rst_n, .cmd, .status,
    .accel_x(in_tdata[15:0]), .accel_y(in_tdata[31:16]), .accel_z(in_tdata[47:32]),
    .second_of_minute(in_tdata[53:48]), .recording_restart(in_tuser),
    .stuck_limit, .average_gain, .range_enter, .range_exit, .rate_low, .rate_high,
    .result
  );

  assign out_tdata = {1'b0, result};

  // no new sample taken while the datapath is busy
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("sample accepted while busy");
  // alarm and release never together
  a_stuck: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("stuck alarm and release together");
  // range alarm and restore never together
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[18] && out_tdata[19]))
    else $error("range alarm and restore together");
endmodule
